// File: rtl/led_matrix_clock_scanner_core_macros.svh
// assertion macros shared by the column scanner rtl
`ifndef LED_MATRIX_CLOCK_SCANNER_CORE_MACROS_SVH
`define LED_MATRIX_CLOCK_SCANNER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LMCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define LMCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lmcs_pkg.sv
// types, tables and constants of the led matrix column scanner
package lmcs_pkg;

  // request codes
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // mode key codes
  localparam logic [1:0] MODE_LOGO    = 2'd0;
  localparam logic [1:0] MODE_STATION = 2'd1;
  localparam logic [1:0] MODE_SECONDS = 2'd2;
  localparam logic [1:0] MODE_TIME    = 2'd3;

  // colon flash phases
  localparam logic [1:0] PH_OFF  = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;
  localparam logic [1:0] PH_HOLD = 2'd3;

  // state memory entries
  localparam logic ENTRY_VALUES = 1'b0;
  localparam logic ENTRY_FLASH  = 1'b1;
  localparam int   REC_W        = 32;
  localparam int   REC_DEPTH    = 2;

  // prescaler and flash limits
  localparam logic [7:0] FINE_TOP        = 8'd200;
  localparam logic [6:0] SCROLL_COARSE_TOP = 7'd100;
  localparam logic [3:0] FLASH_ON_COUNT  = 4'd8;
  localparam logic [3:0] FLASH_GAP_COUNT = 4'd6;
  localparam logic [7:0] COLON_ROW       = 8'h66;
  localparam int         OFFSET_W        = 6;

  // range limits of the digit values
  localparam logic [7:0] HOUR_MAX    = 8'd23;
  localparam logic [7:0] MINSEC_MAX  = 8'd59;
  localparam logic [7:0] STATION_MAX = 8'd99;

  // column layout
  localparam logic [4:0] COL_HT_FIRST = 5'd1;
  localparam logic [4:0] COL_HT_LAST  = 5'd5;
  localparam logic [4:0] COL_HO_FIRST = 5'd8;
  localparam logic [4:0] COL_HO_LAST  = 5'd12;
  localparam logic [4:0] COL_COLON_A  = 5'd15;
  localparam logic [4:0] COL_COLON_B  = 5'd16;
  localparam logic [4:0] COL_T_FIRST  = 5'd19;
  localparam logic [4:0] COL_T_LAST   = 5'd23;
  localparam logic [4:0] COL_O_FIRST  = 5'd26;
  localparam logic [4:0] COL_O_LAST   = 5'd30;

  typedef struct packed {
    logic       action;
    logic [1:0] keys;
    logic [7:0] new_hour;
    logic [7:0] new_minute;
    logic [7:0] new_second;
    logic [7:0] new_station;
  } lmcs_in_t;

  typedef struct packed {
    logic [6:0] column_drive;
    logic [7:0] row_pattern;
  } lmcs_out_t;

  // host values record, entry ENTRY_VALUES
  typedef struct packed {
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic [7:0] station;
  } lmcs_values_t;

  // colon flash record, entry ENTRY_FLASH
  typedef struct packed {
    logic [7:0] last_second;
    logic [1:0] phase;
    logic [7:0] fine;
    logic [3:0] coarse;
  } lmcs_flash_t;

  localparam lmcs_values_t VALUES_RESET = '{hour: 8'd23, minute: 8'd59,
                                            second: 8'd47, station: 8'd98};
  localparam lmcs_flash_t  FLASH_RESET  = '0;

  localparam logic [6:0] COL_CODE [0:31] = '{
    7'h08, 7'h09, 7'h0A, 7'h0B, 7'h0C, 7'h0D, 7'h0E, 7'h0F,
    7'h10, 7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17,
    7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27,
    7'h40, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47
  };

  localparam logic [7:0] GLYPH [0:9][0:4] = '{
    '{8'h7E, 8'h81, 8'h81, 8'h81, 8'h7E},
    '{8'h00, 8'h82, 8'hFF, 8'h80, 8'h00},
    '{8'hC2, 8'hA1, 8'h91, 8'h89, 8'h86},
    '{8'h41, 8'h81, 8'h89, 8'h95, 8'h63},
    '{8'h38, 8'h24, 8'h22, 8'hFF, 8'h20},
    '{8'h4F, 8'h89, 8'h89, 8'h89, 8'h71},
    '{8'h7C, 8'h92, 8'h91, 8'h91, 8'h60},
    '{8'h01, 8'h01, 8'hF9, 8'h05, 8'h03},
    '{8'h66, 8'h99, 8'h91, 8'h99, 8'h66},
    '{8'h06, 8'h89, 8'h89, 8'h49, 8'h3E}
  };

  localparam logic [7:0] LOGO [0:31] = '{
    8'h3F, 8'hA1, 8'hE1, 8'hE1, 8'hE1, 8'hE1, 8'hA1, 8'h3F,
    8'h00, 8'h06, 8'h05, 8'h09, 8'h91, 8'hE1, 8'hE1, 8'h91,
    8'h09, 8'h05, 8'h06, 8'h00, 8'hC0, 8'hC0, 8'hF8, 8'h88,
    8'h8F, 8'h81, 8'h8F, 8'h88, 8'hF8, 8'hC0, 8'hC0, 8'h00
  };

  // tens digit of a value below 128, by reciprocal multiply
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = {8'b0, v} * 15'd205;
    return p[14:11];
  endfunction

endpackage

// File: rtl/led_matrix_clock_scanner_core.sv
// top level of the led matrix column scanner
// One request per clock cycle while the output is not stalled. A request is
// accepted into a two-step flow: at acceptance the host value record and the
// colon flash record are read from the state memory into registers, in the
// next cycle the column is computed, and when the step advances any changed
// record is written back and a scan tick's result lands in the output
// register. Back-to-back requests that touch the same record are forwarded
// from the write port, so a colon column pair or an update right before a
// tick does not stall the flow. Host updates take the same slot and produce
// no result. The state memory starts from the reset values through per-entry
// valid bits; no clearing pass is needed after reset.
module led_matrix_clock_scanner_core #(
  parameter int SCROLL_SPAN = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lmcs_pkg::lmcs_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lmcs_pkg::lmcs_out_t out_data
);
  import lmcs_pkg::*;
  `include "led_matrix_clock_scanner_core_macros.svh"

  localparam logic [OFFSET_W-1:0] SPAN = OFFSET_W'(SCROLL_SPAN);

  // pipeline control
  logic      s1_v_r;
  lmcs_in_t  s1_req_r;
  logic      s1_adv;
  logic      in_acc;
  logic      out_valid_r;
  lmcs_out_t out_data_r;

  // register state
  logic [4:0]          col_r;
  logic [7:0]          sc_fine_r;
  logic [6:0]          sc_coarse_r;
  logic                sc_dir_r;
  logic [OFFSET_W-1:0] sc_offset_r;
  logic [4:0]          col_nxt;
  logic [7:0]          sc_fine_nxt;
  logic [6:0]          sc_coarse_nxt;
  logic                sc_dir_nxt;
  logic [OFFSET_W-1:0] sc_offset_nxt;

  // state memory ports and forwarding
  logic             ram_we;
  logic             ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic [REC_W-1:0] ram_q_a;
  logic [REC_W-1:0] ram_q_b;
  logic [1:0]       vld_r;
  logic [1:0]       rd_vld_r;
  logic             byp_a_r;
  logic             byp_b_r;
  logic [REC_W-1:0] byp_data_r;

  lmcs_values_t vals;
  lmcs_flash_t  fl;
  lmcs_flash_t  fl_nxt;
  lmcs_out_t    res;

  logic       tick;
  logic [1:0] mode;
  logic       colon_visit;
  logic [7:0] colon_row;
  logic [7:0] lv;
  logic       lv_ok;
  logic       hr_ok;
  logic [7:0] dv;
  logic       d_ok;
  logic       d_tens;
  logic [4:0] d_first;
  logic       d_sel;
  logic [3:0] d_t;
  logic [3:0] d_o;
  logic [3:0] d_dig;
  logic [4:0] d_pos;
  logic [7:0] f_fine;
  logic [3:0] f_coarse;
  logic [3:0] f_limit;

  // handshake
  assign s1_adv   = s1_v_r && ((s1_req_r.action == ACT_UPDATE) || !out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign tick     = s1_req_r.action == ACT_TICK;
  assign mode     = s1_req_r.keys;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_data;
    end
  end

  // state memory
  lmcs_ram #(.WIDTH(REC_W), .DEPTH(REC_DEPTH)) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (in_acc),
    .raddr_a (ENTRY_VALUES),
    .raddr_b (ENTRY_FLASH),
    .rdata_a (ram_q_a),
    .rdata_b (ram_q_b)
  );

  // valid bits and forwarding of a write that meets the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 2'b00;
      rd_vld_r <= 2'b00;
      byp_a_r  <= 1'b0;
      byp_b_r  <= 1'b0;
    end else begin
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_r <= vld_r;
        byp_a_r  <= ram_we && (ram_waddr == ENTRY_VALUES);
        byp_b_r  <= ram_we && (ram_waddr == ENTRY_FLASH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_data_r <= ram_wdata;
    end
  end

  // effective records
  always_comb begin
    if (byp_a_r) begin
      vals = lmcs_values_t'(byp_data_r);
    end else if (rd_vld_r[ENTRY_VALUES]) begin
      vals = lmcs_values_t'(ram_q_a);
    end else begin
      vals = VALUES_RESET;
    end
    if (byp_b_r) begin
      fl = lmcs_flash_t'(byp_data_r[$bits(lmcs_flash_t)-1:0]);
    end else if (rd_vld_r[ENTRY_FLASH]) begin
      fl = lmcs_flash_t'(ram_q_b[$bits(lmcs_flash_t)-1:0]);
    end else begin
      fl = FLASH_RESET;
    end
  end

  // scroll prescaler and bouncing offset
  always_comb begin
    sc_fine_nxt   = sc_fine_r + 8'd1;
    sc_coarse_nxt = sc_coarse_r;
    sc_dir_nxt    = sc_dir_r;
    sc_offset_nxt = sc_offset_r;
    if (sc_fine_nxt >= FINE_TOP) begin
      sc_fine_nxt   = 8'd0;
      sc_coarse_nxt = sc_coarse_r + 7'd1;
    end
    if (sc_coarse_nxt >= SCROLL_COARSE_TOP) begin
      sc_coarse_nxt = 7'd0;
      if (!sc_dir_r) begin
        sc_offset_nxt = sc_offset_r + OFFSET_W'(1);
        if (sc_offset_nxt == SPAN) begin
          sc_dir_nxt = 1'b1;
        end
      end else begin
        sc_offset_nxt = sc_offset_r - OFFSET_W'(1);
        if (sc_offset_nxt == '0) begin
          sc_dir_nxt = 1'b0;
        end
      end
    end
    col_nxt = col_r + 5'd1;
  end

  // colon flash sequence on a time-mode colon visit
  assign colon_visit = (mode == MODE_TIME) && ((col_r == COL_COLON_A) || (col_r == COL_COLON_B));

  always_comb begin
    fl_nxt = fl;
    if (vals.second != fl.last_second) begin
      fl_nxt.phase       = PH_ON;
      fl_nxt.last_second = vals.second;
    end
    colon_row = ((fl_nxt.phase == PH_ON) || (fl_nxt.phase == PH_HOLD)) ? COLON_ROW : 8'd0;
    f_limit   = (fl_nxt.phase == PH_ON) ? FLASH_ON_COUNT : FLASH_GAP_COUNT;
    f_fine    = fl_nxt.fine + 8'd1;
    f_coarse  = fl_nxt.coarse + 4'd1;
    if ((fl_nxt.phase == PH_ON) || (fl_nxt.phase == PH_GAP)) begin
      fl_nxt.fine = f_fine;
      if (f_fine >= FINE_TOP) begin
        fl_nxt.fine   = 8'd0;
        fl_nxt.coarse = f_coarse;
        if (f_coarse >= f_limit) begin
          fl_nxt.coarse = 4'd0;
          fl_nxt.phase  = fl_nxt.phase + 2'd1;
        end
      end
    end
  end

  // digit value chosen by the mode
  always_comb begin
    case (mode)
      MODE_STATION: lv = vals.station;
      MODE_SECONDS: lv = vals.second;
      default:      lv = vals.minute;
    endcase
    lv_ok = (mode == MODE_STATION) ? (lv <= STATION_MAX) : (lv <= MINSEC_MAX);
    hr_ok = vals.hour <= HOUR_MAX;
  end

  // digit column decode
  always_comb begin
    d_sel   = 1'b1;
    d_tens  = 1'b1;
    d_first = COL_T_FIRST;
    dv      = lv;
    d_ok    = lv_ok;
    if ((col_r >= COL_T_FIRST) && (col_r <= COL_T_LAST)) begin
      d_tens  = 1'b1;
      d_first = COL_T_FIRST;
    end else if ((col_r >= COL_O_FIRST) && (col_r <= COL_O_LAST)) begin
      d_tens  = 1'b0;
      d_first = COL_O_FIRST;
    end else if ((mode == MODE_TIME) && (col_r >= COL_HT_FIRST) && (col_r <= COL_HT_LAST)) begin
      d_tens  = 1'b1;
      d_first = COL_HT_FIRST;
      dv      = vals.hour;
      d_ok    = hr_ok;
    end else if ((mode == MODE_TIME) && (col_r >= COL_HO_FIRST) && (col_r <= COL_HO_LAST)) begin
      d_tens  = 1'b0;
      d_first = COL_HO_FIRST;
      dv      = vals.hour;
      d_ok    = hr_ok;
    end else begin
      d_sel = 1'b0;
    end
    d_t   = div10(dv[6:0]);
    d_o   = 4'(dv[6:0] - {d_t, 3'b000} - {2'b00, d_t, 1'b0});
    d_dig = d_tens ? d_t : d_o;
    d_pos = col_r - d_first;
  end

  // result of a scan tick
  always_comb begin
    res = '0;
    if (mode == MODE_LOGO) begin
      res.column_drive = COL_CODE[col_r];
      res.row_pattern  = LOGO[col_r + sc_offset_nxt[4:0]];
    end else if (d_sel) begin
      if (d_ok) begin
        res.column_drive = COL_CODE[col_r];
        res.row_pattern  = GLYPH[d_dig][d_pos[2:0]];
      end
    end else if ((mode != MODE_STATION) &&
                 ((col_r == COL_COLON_A) || (col_r == COL_COLON_B))) begin
      res.column_drive = COL_CODE[col_r];
      res.row_pattern  = (mode == MODE_SECONDS) ? COLON_ROW : colon_row;
    end
  end

  // write back of a changed record
  always_comb begin
    ram_we    = s1_adv && (!tick || colon_visit);
    ram_waddr = tick ? ENTRY_FLASH : ENTRY_VALUES;
    if (tick) begin
      ram_wdata = {{(REC_W - $bits(lmcs_flash_t)){1'b0}}, fl_nxt};
    end else begin
      ram_wdata = {s1_req_r.new_hour, s1_req_r.new_minute,
                   s1_req_r.new_second, s1_req_r.new_station};
    end
  end

  // column and scroll registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= 5'd0;
      sc_fine_r   <= 8'd0;
      sc_coarse_r <= 7'd0;
      sc_dir_r    <= 1'b0;
      sc_offset_r <= '0;
    end else if (s1_adv && tick) begin
      col_r       <= col_nxt;
      sc_fine_r   <= sc_fine_nxt;
      sc_coarse_r <= sc_coarse_nxt;
      sc_dir_r    <= sc_dir_nxt;
      sc_offset_r <= sc_offset_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && tick) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `LMCS_ASSERT_IMP(a_blank_row, clk, rst_n, out_valid_r && (out_data_r.column_drive == 7'd0),
                   out_data_r.row_pattern == 8'd0, "blanked column drives a row")
  `LMCS_ASSERT_NXT(a_tick_result, clk, rst_n, s1_adv && tick, out_valid_r,
                   "scan tick left no result")
  `LMCS_ASSERT_IMP(a_flash_phase, clk, rst_n, ram_we && (ram_waddr == ENTRY_FLASH),
                   (fl_nxt.phase != PH_OFF) || (fl_nxt == fl),
                   "colon record changed while the colon stays off")
  `LMCS_ASSERT_IMP(a_offset_span, clk, rst_n, s1_v_r, sc_offset_r <= SPAN,
                   "scroll offset beyond span")

endmodule

// File: rtl/lmcs_ram.sv
// generic ram with one write port and two registered read ports
module lmcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
